@@ hdl/etl_pkg.sv @@
// Package for the expression token lexer: character codes, token kinds,
// lexer mode and radix encodings, and the structs passed between modules.
// No dependencies.
package etl_pkg;

  // Width of the token value port; the accumulator width is a parameter.
  localparam int TOKEN_VALUE_WIDTH = 32;
  localparam int DEFAULT_VALUE_WIDTH = 32;

  // Depth of the result queue, a power of two of at least two.
  localparam int TOKEN_FIFO_DEPTH = 4;

  // Character codes.
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_F   = 8'h46;
  localparam logic [7:0] CH_UP_X   = 8'h58;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_F   = 8'h66;
  localparam logic [7:0] CH_LO_X   = 8'h78;

  // Digit value given to a byte that is no hex digit at all.
  localparam logic [4:0] NO_DIGIT  = 5'd16;

  typedef enum logic [3:0] {
    K_NUMBER   = 4'd0,
    K_PLUS     = 4'd1,
    K_MINUS    = 4'd2,
    K_STAR     = 4'd3,
    K_LPAREN   = 4'd4,
    K_RPAREN   = 4'd5,
    K_CARET    = 4'd6,
    K_NEWLINE  = 4'd7,
    K_NONSENSE = 4'd8,
    K_END      = 4'd9
  } token_kind_t;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_COMMENT = 2'd1,
    MODE_NUMBER  = 2'd2,
    MODE_ZERO    = 2'd3
  } lex_mode_t;

  typedef enum logic [1:0] {
    RADIX_DEC = 2'd0,
    RADIX_OCT = 2'd1,
    RADIX_HEX = 2'd2
  } radix_t;

  typedef struct packed {
    token_kind_t                    kind;
    logic [TOKEN_VALUE_WIDTH-1:0]   value;
    logic                           last;
  } token_t;

  // Tokens produced by one item, in order: count is 0, 1 or 2.
  typedef struct packed {
    logic [1:0] count;
    token_t     tok0;
    token_t     tok1;
  } token_pair_t;

  typedef struct packed {
    logic not_empty;
    logic room_for_pair;
  } fifo_status_t;

endpackage

@@ hdl/etl_step.sv @@
// Combinational lexer step: classifies one byte against the current mode,
// radix and accumulator and gives the next state and up to two tokens.
// Depends on etl_pkg.
module etl_step
  import etl_pkg::*;
#(
  parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
  input  logic [7:0]             in_byte,
  input  logic                   end_of_input,
  input  lex_mode_t              mode,
  input  radix_t                 radix,
  input  logic [VALUE_WIDTH-1:0] acc,
  output lex_mode_t              mode_next,
  output radix_t                 radix_next,
  output logic [VALUE_WIDTH-1:0] acc_next,
  output token_pair_t            tokens
);

  logic [4:0]             dig;
  radix_t                 eff_radix;
  logic                   digit_ok;
  logic [VALUE_WIDTH-1:0] dig_ext;
  logic [VALUE_WIDTH-1:0] times2;
  logic [VALUE_WIDTH-1:0] times8;
  logic [VALUE_WIDTH-1:0] times16;
  logic [VALUE_WIDTH-1:0] acc_mac;
  logic [63:0]            acc_wide;
  logic [TOKEN_VALUE_WIDTH-1:0] acc_val;
  logic                   is_x;

  logic                   fr_emit;
  token_kind_t            fr_kind;
  lex_mode_t              fr_mode;
  logic [VALUE_WIDTH-1:0] fr_acc;

  logic [1:0]             cnt;
  token_kind_t            kind0;
  token_kind_t            kind1;
  logic [TOKEN_VALUE_WIDTH-1:0] val0;

  // Digit value of the byte in any base up to sixteen.
  always_comb begin
    if (in_byte >= CH_ZERO && in_byte <= CH_NINE) begin
      dig = 5'(in_byte - CH_ZERO);
    end else if (in_byte >= CH_UP_A && in_byte <= CH_UP_F) begin
      dig = 5'(in_byte - CH_UP_A + 8'd10);
    end else if (in_byte >= CH_LO_A && in_byte <= CH_LO_F) begin
      dig = 5'(in_byte - CH_LO_A + 8'd10);
    end else begin
      dig = NO_DIGIT;
    end
  end

  // After a leading zero any byte but x selects octal.
  assign eff_radix = (mode == MODE_ZERO) ? RADIX_OCT : radix;
  assign is_x      = (in_byte == CH_LO_X) || (in_byte == CH_UP_X);

  assign dig_ext = VALUE_WIDTH'(dig);
  assign times2  = {acc[VALUE_WIDTH-2:0], 1'b0};
  assign times8  = {acc[VALUE_WIDTH-4:0], 3'b000};
  assign times16 = {acc[VALUE_WIDTH-5:0], 4'b0000};

  always_comb begin
    case (eff_radix)
      RADIX_OCT: begin
        digit_ok = (dig < 5'd8);
        acc_mac  = times8 + dig_ext;
      end
      RADIX_HEX: begin
        digit_ok = (dig < 5'd16);
        acc_mac  = times16 + dig_ext;
      end
      default: begin
        digit_ok = (dig < 5'd10);
        acc_mac  = times8 + times2 + dig_ext;
      end
    endcase
  end

  assign acc_wide = 64'(acc);
  assign acc_val  = acc_wide[TOKEN_VALUE_WIDTH-1:0];

  // How a byte is lexed when it starts a fresh token.
  always_comb begin
    fr_emit = 1'b0;
    fr_kind = K_NONSENSE;
    fr_mode = MODE_IDLE;
    fr_acc  = '0;
    case (in_byte)
      CH_SPACE, CH_TAB, CH_CR: begin
        fr_emit = 1'b0;
      end
      CH_HASH:   fr_mode = MODE_COMMENT;
      CH_PLUS:   begin fr_emit = 1'b1; fr_kind = K_PLUS;    end
      CH_MINUS:  begin fr_emit = 1'b1; fr_kind = K_MINUS;   end
      CH_STAR:   begin fr_emit = 1'b1; fr_kind = K_STAR;    end
      CH_LPAREN: begin fr_emit = 1'b1; fr_kind = K_LPAREN;  end
      CH_RPAREN: begin fr_emit = 1'b1; fr_kind = K_RPAREN;  end
      CH_CARET:  begin fr_emit = 1'b1; fr_kind = K_CARET;   end
      CH_LF:     begin fr_emit = 1'b1; fr_kind = K_NEWLINE; end
      CH_ZERO:   fr_mode = MODE_ZERO;
      default: begin
        if (in_byte > CH_ZERO && in_byte <= CH_NINE) begin
          fr_mode = MODE_NUMBER;
          fr_acc  = dig_ext;
        end else begin
          fr_emit = 1'b1;
          fr_kind = K_NONSENSE;
        end
      end
    endcase
  end

  always_comb begin
    mode_next  = mode;
    radix_next = radix;
    acc_next   = acc;
    cnt        = 2'd0;
    kind0      = K_NONSENSE;
    kind1      = K_NONSENSE;
    val0       = '0;
    if (end_of_input) begin
      // A pending number goes out ahead of the end token.
      if (mode == MODE_NUMBER || mode == MODE_ZERO) begin
        cnt   = 2'd2;
        kind0 = K_NUMBER;
        val0  = acc_val;
        kind1 = K_END;
      end else begin
        cnt   = 2'd1;
        kind0 = K_END;
      end
      mode_next  = MODE_IDLE;
      radix_next = RADIX_DEC;
      acc_next   = '0;
    end else begin
      case (mode)
        MODE_COMMENT: begin
          if (in_byte == CH_LF) begin
            cnt       = 2'd1;
            kind0     = K_NEWLINE;
            mode_next = MODE_IDLE;
          end
        end
        MODE_ZERO, MODE_NUMBER: begin
          if (mode == MODE_ZERO && is_x) begin
            mode_next  = MODE_NUMBER;
            radix_next = RADIX_HEX;
            acc_next   = '0;
          end else if (digit_ok) begin
            mode_next  = MODE_NUMBER;
            radix_next = eff_radix;
            acc_next   = acc_mac;
          end else begin
            // The number ends and the byte is lexed afresh.
            kind0      = K_NUMBER;
            val0       = acc_val;
            kind1      = fr_kind;
            cnt        = fr_emit ? 2'd2 : 2'd1;
            mode_next  = fr_mode;
            radix_next = RADIX_DEC;
            acc_next   = fr_acc;
          end
        end
        default: begin
          mode_next  = fr_mode;
          radix_next = RADIX_DEC;
          acc_next   = fr_acc;
          if (fr_emit) begin
            cnt   = 2'd1;
            kind0 = fr_kind;
          end
        end
      endcase
    end
  end

  assign tokens.count      = cnt;
  assign tokens.tok0.kind  = kind0;
  assign tokens.tok0.value = val0;
  assign tokens.tok0.last  = (cnt == 2'd1);
  assign tokens.tok1.kind  = kind1;
  assign tokens.tok1.value = '0;
  assign tokens.tok1.last  = 1'b1;

endmodule

@@ hdl/etl_token_fifo.sv @@
// Small result queue that takes up to two tokens a cycle and gives one.
// Depends on etl_pkg.
module etl_token_fifo
  import etl_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  token_pair_t  push,
  input  logic         pop,
  output token_t       head,
  output fifo_status_t status
);

  localparam int AW = $clog2(TOKEN_FIFO_DEPTH);

  token_t        entries [TOKEN_FIFO_DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;
  logic [AW-1:0] wr_ptr_inc;
  logic [AW-1:0] wr_ptr_next;
  logic [AW-1:0] rd_ptr_next;
  logic [AW:0]   count_next;

  assign wr_ptr_inc  = wr_ptr + AW'(1);
  assign wr_ptr_next = wr_ptr + AW'(push.count);
  assign rd_ptr_next = pop ? rd_ptr + AW'(1) : rd_ptr;
  assign count_next  = count + (AW+1)'(push.count) - (AW+1)'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.tok0;
    end
    if (push.count == 2'd2) begin
      entries[wr_ptr_inc] <= push.tok1;
    end
  end

  assign head                 = entries[rd_ptr];
  assign status.not_empty     = (count != '0);
  assign status.room_for_pair = (count <= (AW+1)'(TOKEN_FIFO_DEPTH - 2));

endmodule

@@ hdl/expression_token_lexer.sv @@
// Top level of the expression token lexer: input register, lexer state,
// lexer step and result queue. Depends on etl_pkg, etl_step, etl_token_fifo.
//
// Use: the sender offers one item per cycle on in_valid with in_byte and
// end_of_input; the item is taken at a rising edge where in_valid is high
// and in_stall is low. Each item gives zero, one or two tokens on the
// result channel (out_valid, token_kind, token_value, last_of_item); a
// token is taken at an edge where out_valid is high and out_stall is low.
// last_of_item marks the final token of the item that caused it.
// An item is held in the input register after it is taken and is lexed
// once the queue has room for two tokens; its tokens are written into the
// result queue, and the first is shown from the queue head.
// Throughput: one item per cycle while items give at most one token each
// and the receiver does not stall; the result side gives one token per
// cycle, so an item that ends a number and is itself a token sends two.
// The lexer step waits until the four-entry result queue has room for two
// tokens, and while it waits in_stall is raised.
// When the receiver stalls, the queue fills and then in_stall holds the
// sender; no token is lost or repeated. Reset (rst, synchronous) empties
// the queue and the input register and returns the lexer to idle with a
// zero accumulator and decimal radix. An end-of-input item does the same
// after flushing any pending number and sending the end token.
module expression_token_lexer
  import etl_pkg::*;
#(
  parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [7:0]                   in_byte,
  input  logic                         end_of_input,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [3:0]                   token_kind,
  output logic [TOKEN_VALUE_WIDTH-1:0] token_value,
  output logic                         last_of_item
);

  // Input register: the item waiting to be lexed.
  logic                   s1_valid;
  logic [7:0]             s1_byte;
  logic                   s1_eoi;

  // Lexer state.
  lex_mode_t              mode;
  radix_t                 radix;
  logic [VALUE_WIDTH-1:0] acc;

  lex_mode_t              mode_next;
  radix_t                 radix_next;
  logic [VALUE_WIDTH-1:0] acc_next;
  token_pair_t            step_tokens;
  token_pair_t            push;
  token_t                 head;
  fifo_status_t           fifo_st;

  logic                   in_accept;
  logic                   consume;
  logic                   pop;

  // The held item is lexed once the queue can take both possible tokens.
  assign consume   = s1_valid && fifo_st.room_for_pair;
  assign in_stall  = s1_valid && !consume;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_accept || (s1_valid && !consume);
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_byte <= in_byte;
      s1_eoi  <= end_of_input;
    end
  end

  etl_step #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_step (
    .in_byte      (s1_byte),
    .end_of_input (s1_eoi),
    .mode         (mode),
    .radix        (radix),
    .acc          (acc),
    .mode_next    (mode_next),
    .radix_next   (radix_next),
    .acc_next     (acc_next),
    .tokens       (step_tokens)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= MODE_IDLE;
      radix <= RADIX_DEC;
      acc   <= '0;
    end else if (consume) begin
      mode  <= mode_next;
      radix <= radix_next;
      acc   <= acc_next;
    end
  end

  // Only a lexed item pushes tokens into the queue.
  always_comb begin
    push = step_tokens;
    if (!consume) begin
      push.count = 2'd0;
    end
  end

  assign pop = out_valid && !out_stall;

  etl_token_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .pop    (pop),
    .head   (head),
    .status (fifo_st)
  );

  assign out_valid    = fifo_st.not_empty;
  assign token_kind   = head.kind;
  assign token_value  = head.value;
  assign last_of_item = head.last;

  // An end-of-input item leaves the lexer idle with a cleared accumulator.
  assert property (@(posedge clk) disable iff (rst)
    consume && s1_eoi |=> mode == MODE_IDLE && acc == '0 && radix == RADIX_DEC)
    else $error("lexer not back at its start state after end of input");

  // Every end-of-input item produces at least the end token.
  assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_eoi |-> step_tokens.count != 2'd0 && step_tokens.tok0.last ==
      (step_tokens.count == 2'd1))
    else $error("end of input gave no token or a wrong last mark");

  // Inside a comment only a newline or end of input gives a token.
  assert property (@(posedge clk) disable iff (rst)
    s1_valid && mode == MODE_COMMENT && !s1_eoi && s1_byte != CH_LF
      |-> step_tokens.count == 2'd0)
    else $error("token produced inside a comment");

  // A lexed item that gives a token makes the result channel valid next.
  assert property (@(posedge clk) disable iff (rst)
    consume && step_tokens.count != 2'd0 |=> out_valid)
    else $error("lexed token did not reach the result channel");

endmodule
